// ===== rtl/bmtt_pkg.sv =====
// Shared types, constants and codes of the blink marker tracker table.
// Every other file of the block imports this package; it depends on nothing.
package bmtt_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 88;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 12;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_WINDOW_X   = 3'd0,
      REG_WINDOW_Y   = 3'd1,
      REG_PERIOD     = 3'd2,
      REG_TOLERANCE  = 3'd3,
      REG_TARGET_A   = 3'd4,
      REG_TARGET_B   = 3'd5,
      REG_TARGET_C   = 3'd6
   } reg_index_type;

   typedef enum logic [1:0] {
      KIND_DETECT = 2'd0,
      KIND_ENTRY  = 2'd1,
      KIND_EMPTY  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ACT_ADDED   = 3'd0,
      ACT_UPDATED = 3'd1,
      ACT_IGNORED = 3'd2,
      ACT_FULL    = 3'd3,
      ACT_MERGED  = 3'd4
   } action_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_D_SCAN,
      S_D_SQ,
      S_D_SUM,
      S_D_DEC,
      S_D_MUPD,
      S_D_DEL,
      S_D_MOUT,
      S_F_RD,
      S_F_MOD,
      S_F_DUTY,
      S_F_CLS,
      S_F_DEL,
      S_R_OUT
   } state_type;

   typedef struct packed {
      logic [11:0] window_x;
      logic [11:0] window_y;
      logic [7:0]  class_period;
      logic [6:0]  duty_tolerance;
      logic [6:0]  duty_target_a;
      logic [6:0]  duty_target_b;
      logic [6:0]  duty_target_c;
   } cfg_type;

   typedef struct packed {
      logic [15:0]        x;
      logic [15:0]        y;
      logic signed [12:0] move_x;
      logic signed [12:0] move_y;
      logic [15:0]        pixels;
      logic               matched;
      logic [7:0]         active;
      logic [7:0]         idle;
      logic [31:0]        age;
      logic [1:0]         cls;
   } entry_type;

   typedef struct packed {
      logic signed [17:0] mul_a;
      logic signed [17:0] mul_b;
      logic               mod_start;
      logic [31:0]        mod_age;
      logic [7:0]         mod_per;
   } alu_req_type;

   typedef struct packed {
      logic signed [35:0] prod;
      logic               mod_busy;
      logic               rem_zero;
   } alu_rsp_type;

endpackage

// ===== rtl/bmtt_alu.sv =====
// Shared arithmetic unit: a registered signed multiplier and a remainder unit
// that retires one dividend bit per cycle. Depends on bmtt_pkg.
module bmtt_alu (
   input  logic                  clock,
   input  logic                  reset,
   input  bmtt_pkg::alu_req_type alu_req,
   output bmtt_pkg::alu_rsp_type alu_rsp
);
   import bmtt_pkg::*;

   logic signed [35:0] prod_ff, prod_in;
   logic [31:0]        shift_ff, shift_in;
   logic [7:0]         rem_ff, rem_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic [8:0]         trial;

   always_comb begin
      prod_in  = alu_req.mul_a * alu_req.mul_b;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      trial    = {rem_ff, shift_ff[31]};
      if (alu_req.mod_start) begin
         shift_in = alu_req.mod_age;
         rem_in   = '0;
         cnt_in   = 6'd32;
      end else if (cnt_ff != '0) begin
         if (trial >= {1'b0, alu_req.mod_per}) begin
            trial = trial - {1'b0, alu_req.mod_per};
         end
         rem_in   = trial[7:0];
         shift_in = {shift_ff[30:0], 1'b0};
         cnt_in   = cnt_ff - 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign alu_rsp.prod     = prod_ff;
   assign alu_rsp.mod_busy = (cnt_ff != '0);
   assign alu_rsp.rem_zero = (rem_ff == '0);

endmodule

// ===== rtl/bmtt_csr.sv =====
// Configuration registers of the tracker table, written over the csr channel.
// Depends on bmtt_pkg.
module bmtt_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bmtt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bmtt_pkg::CSR_DATA_W-1:0] csr_data,
   output bmtt_pkg::cfg_type               cfg
);
   import bmtt_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_WINDOW_X:  cfg_in.window_x       = csr_data;
            REG_WINDOW_Y:  cfg_in.window_y       = csr_data;
            REG_PERIOD:    cfg_in.class_period   = csr_data[7:0];
            REG_TOLERANCE: cfg_in.duty_tolerance = csr_data[6:0];
            REG_TARGET_A:  cfg_in.duty_target_a  = csr_data[6:0];
            REG_TARGET_B:  cfg_in.duty_target_b  = csr_data[6:0];
            REG_TARGET_C:  cfg_in.duty_target_c  = csr_data[6:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{window_x: 12'd320, window_y: 12'd320, class_period: 8'd60,
                     duty_tolerance: 7'd10, duty_target_a: 7'd25,
                     duty_target_b: 7'd75, duty_target_c: 7'd50};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/blink_marker_tracker_table.sv =====
// Top level of the blink marker tracker table: sequencer, entry table and result register.
// Depends on bmtt_pkg, bmtt_alu and bmtt_csr.
//
// A detection walks every entry in turn: one outside the match window takes only the scan
// state, one inside it also S_D_SQ and S_D_SUM, since both squared distances go through
// the single shared multiplier; a merge then sweeps the table once more downward, one slot
// a cycle. A frame end tick takes each entry through S_F_RD and S_F_CLS, one of nonzero age
// also through a bit-serial remainder against the period and, on a period boundary, through
// the multiplier for the duty test; a dropped entry ends the pass. The entry report that
// follows gives one transfer a cycle while the receiver is ready. The input is not ready
// while an item is being worked on. There is no clearing pass after reset.
module blink_marker_tracker_table (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // pos_x [15:0], pos_y [31:16], blob_pixels [47:32]
   input  logic [bmtt_pkg::REQ_DATA_W-1:0] req_tdata,
   // op [0]
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // slot [4:0], action [7:5], out_x [23:8], out_y [39:24], move_x [52:40],
   // move_y [65:53], marker_class [67:66], frames_seen [83:68], zero [87:84]
   output logic [bmtt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // kind [1:0]
   output logic [1:0]                      rsp_tuser,
   output logic                            rsp_tlast,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bmtt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bmtt_pkg::CSR_DATA_W-1:0] csr_data
);
   import bmtt_pkg::*;

   cfg_type     cfg;
   alu_req_type alu_req;
   alu_rsp_type alu_rsp;

   bmtt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bmtt_alu u_alu (
      .clock   (clock),
      .reset   (reset),
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   entry_type table_ff [TABLE_DEPTH];

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic [15:0]          px_ff, px_in, py_ff, py_in, pix_ff, pix_in;
   logic [TABLE_DEPTH-1:0] mask_ff, mask_in;
   logic [1:0]           hits_ff, hits_in;
   logic signed [17:0]   dy_ff, dy_in;
   logic [32:0]          sq_ff, sq_in;
   logic [33:0]          best_ff, best_in;
   logic [IDX_W-1:0]     distk_ff, distk_in, agek_ff, agek_in, kept_ff, kept_in;
   logic [31:0]          life_ff, life_in;
   entry_type            work_ff, work_in;
   logic                 docls_ff, docls_in;
   logic [2:0]           step_ff, step_in;
   logic [2:0]           fit_ff, fit_in;
   logic                 fithi_ff, fithi_in;
   logic signed [35:0]   num_ff, num_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [1:0]           rsp_kind_ff, rsp_kind_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 we;
   logic [IDX_W-1:0]     wa, ra, tail;
   entry_type            wd, rd, upd, blank;
   logic                 out_free, at_end, hit, den0;
   logic signed [16:0]   dx, dy;
   logic [16:0]          adx, ady;
   logic [33:0]          dsum;
   logic [7:0]           per;
   logic [8:0]           den;
   logic [1:0]           tsel;
   logic [6:0]           tgt;
   logic [7:0]           hi;
   logic signed [8:0]    lo;
   logic [1:0]           new_cls;
   logic                 ign;

   function automatic logic signed [12:0] move_of(logic [15:0] pos, logic [15:0] old);
      logic signed [16:0] diff;
      logic signed [16:0] adj;
      diff = signed'({1'b0, pos}) - signed'({1'b0, old});
      adj  = diff[16] ? diff + 17'sd15 : diff;
      return 13'(adj >>> 4);
   endfunction

   function automatic logic [RSP_DATA_W-1:0] pack(entry_type e, logic [IDX_W-1:0] slot,
                                                 action_type act);
      logic [15:0] frames;
      frames = (e.age[31:16] != '0) ? 16'hFFFF : e.age[15:0];
      return {4'd0, frames, e.cls, e.move_y, e.move_x, e.y, e.x, act, 5'(slot)};
   endfunction

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign at_end   = (idx_ff == count_ff);
   assign tail     = IDX_W'(count_ff - CNT_W'(1));
   assign per      = (cfg.class_period == '0) ? 8'd1 : cfg.class_period;

   always_comb begin
      unique case (state_ff)
         S_D_DEC:                   ra = distk_ff;
         S_D_MUPD, S_D_MOUT:        ra = kept_ff;
         S_D_DEL, S_F_DEL:          ra = tail;
         default:                   ra = idx_ff[IDX_W-1:0];
      endcase
   end

   assign rd = table_ff[ra];

   always_comb begin
      dx   = signed'({1'b0, px_ff}) - signed'({1'b0, rd.x});
      dy   = signed'({1'b0, py_ff}) - signed'({1'b0, rd.y});
      adx  = dx[16] ? 17'(-dx) : 17'(dx);
      ady  = dy[16] ? 17'(-dy) : 17'(dy);
      hit  = (adx <= {5'd0, cfg.window_x}) && (ady <= {5'd0, cfg.window_y});
      dsum = {1'b0, sq_ff} + 34'(alu_rsp.prod[32:0]);
      upd         = rd;
      upd.matched = 1'b1;
      upd.move_x  = move_of(px_ff, rd.x);
      upd.move_y  = move_of(py_ff, rd.y);
      upd.x       = px_ff;
      upd.y       = py_ff;
      upd.pixels  = pix_ff;
      ign   = rd.matched && (rd.y < py_ff);
      blank        = '0;
      blank.x      = px_ff;
      blank.y      = py_ff;
      blank.pixels = pix_ff;
      den   = {1'b0, work_ff.active} + {1'b0, work_ff.idle};
      den0  = (den == '0);
      tsel  = 2'((step_ff - 3'd1) >> 1);
      case (tsel)
         2'd0:    tgt = cfg.duty_target_a;
         2'd1:    tgt = cfg.duty_target_b;
         default: tgt = cfg.duty_target_c;
      endcase
      hi = {1'b0, tgt} + {1'b0, cfg.duty_tolerance};
      lo = signed'({2'b0, tgt}) - signed'({2'b0, cfg.duty_tolerance});
      case (work_ff.cls)
         2'd0:    new_cls = fit_ff[2] ? 2'd3 : (fit_ff[1] ? 2'd2 : (fit_ff[0] ? 2'd1 : 2'd0));
         2'd1:    new_cls = fit_ff[0] ? 2'd1 : 2'd0;
         2'd2:    new_cls = fit_ff[1] ? 2'd2 : 2'd0;
         default: new_cls = fit_ff[2] ? 2'd3 : 2'd0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_tvalid) state_in = req_tuser ? S_F_RD : S_D_SCAN;
         S_D_SCAN: if (at_end) state_in = S_D_DEC;
                   else if (hit) state_in = S_D_SQ;
         S_D_SQ:   state_in = S_D_SUM;
         S_D_SUM:  state_in = S_D_SCAN;
         S_D_DEC:  if (hits_ff == 2'd2) state_in = S_D_MUPD;
                   else if (out_free) state_in = S_IDLE;
         S_D_MUPD: state_in = S_D_DEL;
         S_D_DEL:  if (idx_ff == '0) state_in = S_D_MOUT;
         S_D_MOUT: if (out_free) state_in = S_IDLE;
         S_F_RD:   if (at_end) state_in = S_R_OUT;
                   else if (rd.age == '0) state_in = S_F_CLS;
                   else state_in = S_F_MOD;
         S_F_MOD:  if (!alu_rsp.mod_busy) state_in = alu_rsp.rem_zero ? S_F_DUTY : S_F_CLS;
         S_F_DUTY: if (step_ff == 3'd7) state_in = S_F_CLS;
         S_F_CLS:  state_in = (docls_ff && new_cls == 2'd0) ? S_F_DEL : S_F_RD;
         S_F_DEL:  state_in = S_R_OUT;
         S_R_OUT:  if (out_free && (count_ff == '0 ||
                                    idx_ff == CNT_W'(count_ff - CNT_W'(1))))
                      state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      count_in = count_ff;  idx_in = idx_ff;
      px_in = px_ff;  py_in = py_ff;  pix_in = pix_ff;
      mask_in = mask_ff;  hits_in = hits_ff;  dy_in = dy_ff;  sq_in = sq_ff;
      best_in = best_ff;  distk_in = distk_ff;  agek_in = agek_ff;  kept_in = kept_ff;
      life_in = life_ff;  work_in = work_ff;  docls_in = docls_ff;  step_in = step_ff;
      fit_in = fit_ff;  fithi_in = fithi_ff;  num_in = num_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;  rsp_kind_in = rsp_kind_ff;  rsp_last_in = rsp_last_ff;
      we = 1'b0;  wa = ra;  wd = rd;
      alu_req.mul_a = '0;  alu_req.mul_b = '0;
      alu_req.mod_start = 1'b0;  alu_req.mod_age = rd.age;  alu_req.mod_per = per;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               px_in = req_tdata[15:0];  py_in = req_tdata[31:16];
               pix_in = req_tdata[47:32];
               idx_in = '0;  mask_in = '0;  hits_in = '0;  life_in = '0;
               best_in = '0;  distk_in = '0;  agek_in = '0;
            end
         end
         S_D_SCAN: begin
            if (!at_end) begin
               if (hit) begin
                  mask_in[idx_ff[IDX_W-1:0]] = 1'b1;
                  hits_in = (hits_ff == 2'd2) ? 2'd2 : hits_ff + 2'd1;
                  if (life_ff < rd.age) begin
                     life_in = rd.age;
                     agek_in = idx_ff[IDX_W-1:0];
                  end
                  alu_req.mul_a = 18'(dx);
                  alu_req.mul_b = 18'(dx);
                  dy_in = 18'(dy);
               end else begin
                  idx_in = idx_ff + CNT_W'(1);
               end
            end
         end
         S_D_SQ: begin
            sq_in = alu_rsp.prod[32:0];
            alu_req.mul_a = dy_ff;
            alu_req.mul_b = dy_ff;
         end
         S_D_SUM: begin
            if (hits_ff == 2'd1 || best_ff > dsum) begin
               best_in  = dsum;
               distk_in = idx_ff[IDX_W-1:0];
            end
            idx_in = idx_ff + CNT_W'(1);
         end
         S_D_DEC: begin
            kept_in = (life_ff != '0) ? agek_ff : distk_ff;
            if (hits_ff != 2'd2 && out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_DETECT;
               rsp_last_in  = 1'b1;
               if (hits_ff == 2'd0) begin
                  if (count_ff < CNT_W'(TABLE_DEPTH)) begin
                     we = 1'b1;
                     wa = count_ff[IDX_W-1:0];
                     wd = blank;
                     count_in = count_ff + CNT_W'(1);
                     rsp_data_in = pack(blank, count_ff[IDX_W-1:0], ACT_ADDED);
                  end else begin
                     rsp_data_in = pack(blank, '0, ACT_FULL);
                  end
               end else if (ign) begin
                  rsp_data_in = pack(rd, distk_ff, ACT_IGNORED);
               end else begin
                  we = 1'b1;
                  wa = distk_ff;
                  wd = upd;
                  rsp_data_in = pack(upd, distk_ff, ACT_UPDATED);
               end
            end
         end
         S_D_MUPD: begin
            we = 1'b1;
            wa = kept_ff;
            wd = upd;
            idx_in = CNT_W'(TABLE_DEPTH - 1);
         end
         S_D_DEL: begin
            if (mask_ff[idx_ff[IDX_W-1:0]] && idx_ff[IDX_W-1:0] != kept_ff) begin
               if (idx_ff[IDX_W-1:0] != tail) begin
                  we = 1'b1;
                  wa = idx_ff[IDX_W-1:0];
                  wd = rd;
                  if (tail == kept_ff) kept_in = idx_ff[IDX_W-1:0];
               end
               count_in = count_ff - CNT_W'(1);
            end
            if (idx_ff != '0) idx_in = idx_ff - CNT_W'(1);
         end
         S_D_MOUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_DETECT;
               rsp_last_in  = 1'b1;
               rsp_data_in  = pack(rd, kept_ff, ACT_MERGED);
            end
         end
         S_F_RD: begin
            if (at_end) begin
               idx_in = '0;
            end else begin
               work_in = rd;
               work_in.matched = 1'b0;
               if (rd.matched) begin
                  if (rd.active != 8'hFF) work_in.active = rd.active + 8'd1;
               end else if (rd.idle != 8'hFF) begin
                  work_in.idle = rd.idle + 8'd1;
               end
               docls_in = 1'b0;
               alu_req.mod_start = (rd.age != '0);
            end
         end
         S_F_MOD: begin
            step_in = '0;
         end
         S_F_DUTY: begin
            if (step_ff == 3'd0) begin
               alu_req.mul_a = den0 ? 18'sd0 : 18'(signed'({1'b0, work_ff.active}));
               alu_req.mul_b = 18'sd100;
            end else if (step_ff != 3'd7) begin
               alu_req.mul_a = step_ff[0] ? 18'(signed'({1'b0, hi})) : 18'(lo);
               alu_req.mul_b = den0 ? 18'sd1 : 18'(signed'({1'b0, den}));
            end
            if (step_ff == 3'd1) begin
               num_in = alu_rsp.prod;
            end else if (step_ff != 3'd0 && !step_ff[0]) begin
               fithi_in = (num_ff <= alu_rsp.prod);
            end else if (step_ff != 3'd0) begin
               fit_in[2'((step_ff - 3'd3) >> 1)] = fithi_ff && (num_ff >= alu_rsp.prod);
            end
            step_in = step_ff + 3'd1;
            docls_in = 1'b1;
         end
         S_F_CLS: begin
            if (!(docls_ff && new_cls == 2'd0)) begin
               we = 1'b1;
               wa = idx_ff[IDX_W-1:0];
               wd = work_ff;
               if (docls_ff) begin
                  wd.cls = new_cls;
                  wd.active = '0;
                  wd.idle = '0;
               end
               wd.age = work_ff.age + 32'd1;
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         S_F_DEL: begin
            if (idx_ff[IDX_W-1:0] != tail) begin
               we = 1'b1;
               wa = idx_ff[IDX_W-1:0];
               wd = rd;
            end
            count_in = count_ff - CNT_W'(1);
            idx_in = '0;
         end
         S_R_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (count_ff == '0) begin
                  rsp_kind_in = KIND_EMPTY;
                  rsp_last_in = 1'b1;
                  rsp_data_in = '0;
               end else begin
                  rsp_kind_in = KIND_ENTRY;
                  rsp_last_in = (idx_ff == CNT_W'(count_ff - CNT_W'(1)));
                  rsp_data_in = pack(rd, idx_ff[IDX_W-1:0], ACT_ADDED);
                  idx_in = idx_ff + CNT_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) table_ff[wa] <= wd;
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;  px_ff <= px_in;  py_ff <= py_in;  pix_ff <= pix_in;
      mask_ff <= mask_in;  hits_ff <= hits_in;  dy_ff <= dy_in;
      sq_ff <= sq_in;  best_ff <= best_in;  distk_ff <= distk_in;  agek_ff <= agek_in;
      kept_ff <= kept_in;  life_ff <= life_in;  work_ff <= work_in;  docls_ff <= docls_in;
      step_ff <= step_in;  fit_ff <= fit_in;  fithi_ff <= fithi_in;  num_ff <= num_in;
      rsp_data_ff <= rsp_data_in;  rsp_kind_ff <= rsp_kind_in;  rsp_last_ff <= rsp_last_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== tb/sv/blink_marker_tracker_table_tb.sv =====
// Self-checking testbench of the blink marker tracker table: a directed table and random
// detections and frame ticks, checked against a predictor of the tracking table.
// Depends on bmtt_pkg and the blink_marker_tracker_table top level.
module blink_marker_tracker_table_tb;
   import bmtt_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;

   typedef struct {
      kind_type    kind;
      logic [4:0]  slot;
      action_type  act;
      logic [15:0] x;
      logic [15:0] y;
      logic [12:0] mx;
      logic [12:0] my;
      logic [1:0]  cls;
      logic [15:0] seen;
      logic        last;
   } outcome_type;

   typedef struct {
      logic        op;
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] pix;
      logic        typed;
      outcome_type want;
   } row_type;

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_tvalid = 0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_valid = 0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   blink_marker_tracker_table DUT (.*);

   always #5 clock = ~clock;

   // Shadow of the configuration and of the table.
   int unsigned win_x, win_y, period, tol;
   int unsigned target [3];
   int unsigned count;
   logic [15:0] ent_x [TABLE_DEPTH], ent_y [TABLE_DEPTH], ent_pix [TABLE_DEPTH];
   logic [12:0] ent_mx [TABLE_DEPTH], ent_my [TABLE_DEPTH];
   logic        ent_hit [TABLE_DEPTH];
   int unsigned ent_act [TABLE_DEPTH], ent_idle [TABLE_DEPTH];
   int unsigned ent_age [TABLE_DEPTH];
   int unsigned ent_cls [TABLE_DEPTH];

   outcome_type pending [$];
   int       errors = 0;
   int       cycles = 0;
   int       hold_ask = 0;
   int       hold_left = 0;
   int       pat = 0;
   int       burst_left = 0;
   int unsigned centre_x [6], centre_y [6];

   function automatic outcome_type entry_report(kind_type k, int unsigned i, action_type a,
                                                logic l);
      outcome_type r;
      r.kind = k; r.slot = i[4:0]; r.act = a;
      r.x = ent_x[i]; r.y = ent_y[i]; r.mx = ent_mx[i]; r.my = ent_my[i];
      r.cls = ent_cls[i][1:0];
      r.seen = ent_age[i] > 65535 ? 16'hFFFF : ent_age[i][15:0];
      r.last = l;
      return r;
   endfunction

   function automatic outcome_type plain(kind_type k, action_type a, logic [15:0] x,
                                         logic [15:0] y);
      outcome_type r;
      r.kind = k; r.slot = '0; r.act = a; r.x = x; r.y = y;
      r.mx = '0; r.my = '0; r.cls = '0; r.seen = '0; r.last = 1;
      return r;
   endfunction

   function automatic void drop_entry(int unsigned i);
      int unsigned s;
      if (count == 0) return;
      count--;
      s = count;
      if (i != s) begin
         ent_x[i] = ent_x[s]; ent_y[i] = ent_y[s]; ent_mx[i] = ent_mx[s];
         ent_my[i] = ent_my[s]; ent_pix[i] = ent_pix[s]; ent_hit[i] = ent_hit[s];
         ent_act[i] = ent_act[s]; ent_idle[i] = ent_idle[s];
         ent_age[i] = ent_age[s]; ent_cls[i] = ent_cls[s];
      end
   endfunction

   function automatic void move_entry(int unsigned i, int px, int py, logic [15:0] pix);
      int dx;
      int dy;
      dx = (px - int'(ent_x[i])) / 16;
      dy = (py - int'(ent_y[i])) / 16;
      ent_hit[i] = 1; ent_mx[i] = dx[12:0]; ent_my[i] = dy[12:0];
      ent_x[i] = px[15:0]; ent_y[i] = py[15:0]; ent_pix[i] = pix;
   endfunction

   function automatic bit duty_ok(int unsigned a, int unsigned b, int unsigned t);
      longint num, den, hi, lo;
      num = longint'(a) * 100; den = longint'(a) + longint'(b);
      hi = longint'(t) + longint'(tol); lo = longint'(t) - longint'(tol);
      if (den == 0) begin
         num = 0; den = 1;
      end
      return num <= hi * den && num >= lo * den;
   endfunction

   function automatic void track_detection(int px, int py, logic [15:0] pix);
      int unsigned hits [$];
      int unsigned kept, life, idx, tail, i;
      longint dx, dy, d, best, wx, wy;
      kept = 0; best = 0;
      wx = longint'(win_x); wy = longint'(win_y);
      for (i = 0; i < count; i++) begin
         dx = longint'(px) - longint'(ent_x[i]);
         dy = longint'(py) - longint'(ent_y[i]);
         if (dx <= wx && -dx <= wx && dy <= wy && -dy <= wy) begin
            d = dx * dx + dy * dy;
            if (hits.size() == 0 || best > d) begin
               best = d; kept = i;
            end
            hits.push_back(i);
         end
      end
      if (hits.size() == 0) begin
         if (count < TABLE_DEPTH) begin
            i = count;
            ent_x[i] = px[15:0]; ent_y[i] = py[15:0]; ent_mx[i] = '0; ent_my[i] = '0;
            ent_pix[i] = pix; ent_hit[i] = 0; ent_act[i] = 0; ent_idle[i] = 0;
            ent_age[i] = 0; ent_cls[i] = 0;
            count++;
            pending.push_back(entry_report(KIND_DETECT, i, ACT_ADDED, 1));
         end else
            pending.push_back(plain(KIND_DETECT, ACT_FULL, px[15:0], py[15:0]));
      end else if (hits.size() == 1) begin
         if (ent_hit[kept] && int'(ent_y[kept]) < py)
            pending.push_back(entry_report(KIND_DETECT, kept, ACT_IGNORED, 1));
         else begin
            move_entry(kept, px, py, pix);
            pending.push_back(entry_report(KIND_DETECT, kept, ACT_UPDATED, 1));
         end
      end else begin
         life = 0;
         foreach (hits[k])
            if (life < ent_age[hits[k]]) begin
               life = ent_age[hits[k]]; kept = hits[k];
            end
         move_entry(kept, px, py, pix);
         for (int k = hits.size() - 1; k >= 0; k--) begin
            idx = hits[k];
            if (idx != kept) begin
               tail = count - 1;
               drop_entry(idx);
               if (tail == kept && idx != tail) kept = idx;
            end
         end
         pending.push_back(entry_report(KIND_DETECT, kept, ACT_MERGED, 1));
      end
   endfunction

   function automatic void track_frame_end();
      int unsigned per, c, i;
      per = period == 0 ? 1 : period;
      for (i = 0; i < count; i++) begin
         if (ent_hit[i]) begin
            ent_hit[i] = 0;
            if (ent_act[i] < 255) ent_act[i]++;
         end else if (ent_idle[i] < 255)
            ent_idle[i]++;
         if (ent_age[i] != 0 && ent_age[i] % per == 0) begin
            c = ent_cls[i];
            if (c == 0) begin
               for (int j = 0; j < 3; j++)
                  if (duty_ok(ent_act[i], ent_idle[i], target[j])) c = j + 1;
            end else if (!duty_ok(ent_act[i], ent_idle[i], target[c - 1]))
               c = 0;
            ent_cls[i] = c;
            if (c == 0) begin
               drop_entry(i);
               break;
            end
            ent_act[i] = 0; ent_idle[i] = 0;
         end
         ent_age[i]++;
      end
      if (count == 0)
         pending.push_back(plain(KIND_EMPTY, ACT_ADDED, '0, '0));
      else
         for (i = 0; i < count; i++)
            pending.push_back(entry_report(KIND_ENTRY, i, ACT_ADDED, i + 1 == count));
   endfunction

   task automatic write_reg(reg_index_type r, int unsigned v);
      csr_valid <= 1; csr_index <= r; csr_data <= v[CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      case (r)
         REG_WINDOW_X:  win_x = v & 12'hFFF;
         REG_WINDOW_Y:  win_y = v & 12'hFFF;
         REG_PERIOD:    period = v & 8'hFF;
         REG_TOLERANCE: tol = v & 7'h7F;
         REG_TARGET_A:  target[0] = v & 7'h7F;
         REG_TARGET_B:  target[1] = v & 7'h7F;
         default:       target[2] = v & 7'h7F;
      endcase
   endtask

   task automatic set_all(int unsigned wx, wy, per, tl, ta, tb, tc);
      while (pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      write_reg(REG_WINDOW_X, wx); write_reg(REG_WINDOW_Y, wy);
      write_reg(REG_PERIOD, per); write_reg(REG_TOLERANCE, tl);
      write_reg(REG_TARGET_A, ta); write_reg(REG_TARGET_B, tb);
      write_reg(REG_TARGET_C, tc);
      @(posedge clock);
   endtask

   // Offers one item, waits for its transfer and then perhaps opens a gap.
   task automatic send(logic op, logic [15:0] x, logic [15:0] y, logic [15:0] pix,
                       bit typed, outcome_type want);
      req_tvalid <= 1; req_tuser <= op; req_tdata <= {pix, y, x};
      do @(posedge clock); while (!req_tready);
      if (op) track_frame_end();
      else track_detection(int'(x), int'(y), pix);
      if (typed) begin
         void'(pending.pop_back());
         pending.push_back(want);
      end
      if (burst_left > 0)
         burst_left--;
      else begin
         burst_left = $urandom_range(0, 10);
         if ($urandom_range(0, 3) != 0) begin
            req_tvalid <= 0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   endtask

   function automatic logic [15:0] near(int unsigned c, int unsigned w);
      int v;
      v = int'(c) + $urandom_range(0, 3 * w + 4) - int'(3 * w / 2 + 2);
      return v < 0 ? 16'd0 : (v > 65535 ? 16'hFFFF : v[15:0]);
   endfunction

   task automatic random_phase(int n, int tick_odds, int spread);
      outcome_type none;
      int unsigned c;
      foreach (centre_x[i]) begin
         centre_x[i] = $urandom_range(0, 65535); centre_y[i] = $urandom_range(0, 65535);
      end
      for (int i = 0; i < n; i++) begin
         c = $urandom_range(0, 5);
         if ($urandom_range(0, tick_odds - 1) == 0)
            send(1'b1, 16'($urandom), 16'($urandom), 16'($urandom), 1'b0, none);
         else if ($urandom_range(0, 99) < spread)
            send(1'b0, 16'($urandom), 16'($urandom), 16'($urandom), 1'b0, none);
         else
            send(1'b0, near(centre_x[c], win_x), near(centre_y[c], win_y), 16'($urandom),
                 1'b0, none);
      end
      req_tvalid <= 0;
   endtask

   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 0;
      end else if (hold_ask) begin
         hold_ask = 0;
         hold_left <= 3000;
         rsp_tready <= 0;
      end else begin
         pat <= pat + 1;
         rsp_tready <= pat[8] ? 1'b1 : ($urandom_range(0, 2) != 0);
      end
   end

   always @(posedge clock) begin
      outcome_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending.size() == 0) begin
            $display("%0t: result with nothing expected, actual %h", $time, rsp_tdata);
            errors++;
         end else begin
            w = pending.pop_front();
            if (rsp_tuser != w.kind || rsp_tdata[4:0] != w.slot ||
                rsp_tdata[7:5] != w.act || rsp_tdata[23:8] != w.x ||
                rsp_tdata[39:24] != w.y || rsp_tdata[52:40] != w.mx ||
                rsp_tdata[65:53] != w.my || rsp_tdata[67:66] != w.cls ||
                rsp_tdata[83:68] != w.seen || rsp_tdata[87:84] != 0 ||
                rsp_tlast != w.last) begin
               $display("%0t: mismatch, expected kind %0d slot %0d act %0d x %h y %h %s",
                        $time, w.kind, w.slot, w.act, w.x, w.y,
                        $sformatf("mx %h my %h cls %0d seen %0d last %b",
                                  w.mx, w.my, w.cls, w.seen, w.last));
               $display("%0t: actual   kind %0d slot %0d act %0d x %h y %h %s",
                        $time, rsp_tuser, rsp_tdata[4:0], rsp_tdata[7:5],
                        rsp_tdata[23:8], rsp_tdata[39:24],
                        $sformatf("mx %h my %h cls %0d seen %0d last %b pad %h",
                                  rsp_tdata[52:40], rsp_tdata[65:53], rsp_tdata[67:66],
                                  rsp_tdata[83:68], rsp_tlast, rsp_tdata[87:84]));
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      row_type rows [$];
      row_type r;
      outcome_type none;
      win_x = 320; win_y = 320; period = 60; tol = 10;
      target[0] = 25; target[1] = 75; target[2] = 50;
      count = 0;
      r.typed = 0; r.want = plain(KIND_DETECT, ACT_ADDED, '0, '0);
      // Ticks on an empty table, single adds, updates, merges and an ignored detection, extremes of every field.
      r.op = 1; r.x = 0; r.y = 0; r.pix = 0; r.typed = 1;
      r.want = plain(KIND_EMPTY, ACT_ADDED, '0, '0); rows.push_back(r);
      r.op = 0; r.x = 100; r.y = 100; r.pix = 5;
      r.want = plain(KIND_DETECT, ACT_ADDED, 16'd100, 16'd100); rows.push_back(r);
      r.x = 0; r.y = 0; r.pix = 0;
      r.want = plain(KIND_DETECT, ACT_UPDATED, '0, '0);
      r.want.mx = -13'sd6; r.want.my = -13'sd6; rows.push_back(r);
      r.x = 16'hFFFF; r.y = 16'hFFFF; r.pix = 16'hFFFF;
      r.want = plain(KIND_DETECT, ACT_ADDED, 16'hFFFF, 16'hFFFF);
      r.want.slot = 1; rows.push_back(r);
      r.typed = 0;
      r.x = 10; r.y = 20; r.pix = 3; rows.push_back(r);
      r.x = 1000; r.y = 1000; r.pix = 1; rows.push_back(r);
      r.x = 1600; r.y = 1000; r.pix = 2; rows.push_back(r);
      r.x = 1300; r.y = 1000; r.pix = 9; rows.push_back(r);
      r.op = 1; rows.push_back(r);
      r.op = 0; r.x = 5000; r.y = 5000; rows.push_back(r);
      r.x = 5400; r.y = 5000; rows.push_back(r);
      r.op = 1; rows.push_back(r);
      r.op = 0; r.x = 5200; r.y = 5000; rows.push_back(r);
      r.x = 16'hFFFF; r.y = 0; r.pix = 16'hAAAA; rows.push_back(r);
      r.x = 0; r.y = 16'hFFFF; r.pix = 16'h5555; rows.push_back(r);
      r.x = 16'hFF00; r.y = 10; rows.push_back(r);
      r.op = 1; rows.push_back(r);
      r.op = 0; r.x = 5300; r.y = 4990; rows.push_back(r);
      r.x = 5300; r.y = 5100; rows.push_back(r);
      r.op = 1; rows.push_back(r);

      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (rows[i]) send(rows[i].op, rows[i].x, rows[i].y, rows[i].pix,
                             rows[i].typed, rows[i].want);
      req_tvalid <= 0;

      // Narrow window with wide scatter fills the table.
      set_all(0, 0, 255, 100, 0, 100, 50);
      random_phase(30, 12, 70);
      // Widest window with period zero and no tolerance.
      set_all(4095, 4095, 0, 0, 100, 0, 127);
      random_phase(20, 5, 20);
      set_all(64, 96, 2, 20, 30, 70, 50);
      hold_ask = 1;
      random_phase(25, 6, 20);
      set_all(320, 32, 1, 50, 127, 50, 0);
      random_phase(25, 4, 20);

      while (pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule

// ===== blink_marker_tracker_table.f =====
rtl/bmtt_pkg.sv
rtl/bmtt_alu.sv
rtl/bmtt_csr.sv
rtl/blink_marker_tracker_table.sv
tb/sv/blink_marker_tracker_table_tb.sv
